FILE: sv/clu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache lookup and replacement package
// Shared constants, codes, state type and controller/datapath interface types.
// ----------------------------------------------------------------------------
package clu_pkg;

    localparam int unsigned MAX_LINES_DEF = 16;
    localparam int unsigned MAX_ROWS_DEF  = 4;
    localparam int unsigned ADDR_BITS_DEF = 16;

    localparam int unsigned USE_W   = 16;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned LFSR_W  = 16;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned CIDX_W  = 3;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam logic [1:0] MODE_DIRECT = 2'd1;
    localparam logic [1:0] MODE_FULL   = 2'd2;
    localparam logic [1:0] MODE_SET    = 2'd3;

    localparam logic [2:0] POL_RANDOM = 3'd1;
    localparam logic [2:0] POL_FIFO   = 3'd2;
    localparam logic [2:0] POL_LFU    = 3'd3;
    localparam logic [2:0] POL_LRU    = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_POLICY = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_LINES  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SETS   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_WPB    = 3'd4;

    localparam logic [2:0] CFG_MODE_RST   = 3'd1;
    localparam logic [2:0] CFG_POLICY_RST = 3'd2;
    localparam logic [4:0] CFG_LINES_RST  = 5'd8;
    localparam logic [2:0] CFG_SETS_RST   = 3'd2;
    localparam logic [4:0] CFG_WPB_RST    = 5'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLK_GO,
        S_BLK_WT,
        S_MOD_GO,
        S_MOD_WT,
        S_DIR_RD,
        S_DIR_CK,
        S_SCAN_RD,
        S_SCAN_CK,
        S_PICK,
        S_RND_GO,
        S_RND_WT,
        S_UPDATE,
        S_DEC_RD,
        S_DEC_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DV_BLK,
        DV_MOD,
        DV_RAND
    } t_div_sel;

    typedef struct packed {
        logic     idle;
        logic     div_start;
        logic     div_wait;
        t_div_sel div_sel;
        logic     scan_ck;
        logic     dir_ck;
        logic     update;
        logic     dec_wr;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic assoc;
        logic need_rand;
        logic fifo_miss;
        logic last;
        logic out_free;
    } t_status;

endpackage

FILE: sv/clu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clu_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/clu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle and flags completion for one cycle.
// ----------------------------------------------------------------------------
module clu_div #(
    parameter int unsigned DVD_W = 16,
    parameter int unsigned DVS_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int unsigned CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   n_shift;
    logic             n_ge;
    logic [DVS_W:0]   n_diff;

    always_comb begin
        n_shift = {r_rem, r_quot[DVD_W-1]};
        n_ge    = (n_shift >= {1'b0, r_dvs});
        n_diff  = n_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], n_ge};
            r_rem  <= n_ge ? DVS_W'(n_diff) : DVS_W'(n_shift);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

FILE: sv/clu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache lookup controller
// Sequences division, tag scan, victim choice, update and result hand-off.
// ----------------------------------------------------------------------------
module clu_ctrl import clu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid) n_state = S_BLK_GO;
            S_BLK_GO:  n_state = S_BLK_WT;
            S_BLK_WT: begin
                if (i_sts.div_done) begin
                    n_state = S_MOD_GO;
                end
            end
            S_MOD_GO:  n_state = S_MOD_WT;
            S_MOD_WT: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.assoc ? S_SCAN_RD : S_DIR_RD;
                end
            end
            S_DIR_RD:  n_state = S_DIR_CK;
            S_DIR_CK:  n_state = S_DONE;
            S_SCAN_RD: n_state = S_SCAN_CK;
            S_SCAN_CK: n_state = i_sts.last ? S_PICK : S_SCAN_RD;
            S_PICK:    n_state = i_sts.need_rand ? S_RND_GO : S_UPDATE;
            S_RND_GO:  n_state = S_RND_WT;
            S_RND_WT: begin
                if (i_sts.div_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE:  n_state = i_sts.fifo_miss ? S_DEC_RD : S_DONE;
            S_DEC_RD:  n_state = S_DEC_WR;
            S_DEC_WR:  n_state = i_sts.last ? S_DONE : S_DEC_RD;
            S_DONE:    if (i_sts.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DV_BLK;
        unique case (r_state)
            S_IDLE:    o_cmd.idle = 1'b1;
            S_BLK_GO:  o_cmd.div_start = 1'b1;
            S_BLK_WT:  o_cmd.div_wait = 1'b1;
            S_MOD_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_MOD;
            end
            S_MOD_WT: begin
                o_cmd.div_wait = 1'b1;
                o_cmd.div_sel  = DV_MOD;
            end
            S_DIR_CK:  o_cmd.dir_ck = 1'b1;
            S_SCAN_CK: o_cmd.scan_ck = 1'b1;
            S_RND_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_RAND;
            end
            S_RND_WT: begin
                o_cmd.div_wait = 1'b1;
                o_cmd.div_sel  = DV_RAND;
            end
            S_UPDATE:  o_cmd.update = 1'b1;
            S_DEC_WR:  o_cmd.dec_wr = 1'b1;
            S_DONE:    o_cmd.finish = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule

FILE: sv/clu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache lookup datapath
// Configuration, divider, tag and usage stores, scan logic and result register.
// ----------------------------------------------------------------------------
module clu_dp import clu_pkg::*; #(
    parameter int unsigned MAX_LINES = MAX_LINES_DEF,
    parameter int unsigned MAX_ROWS  = MAX_ROWS_DEF,
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEF,
    localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int unsigned LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_sts,
    input  logic                 i_valid,
    input  logic [ADDR_BITS-1:0] i_word_address,
    input  logic                 i_cfg_valid,
    input  logic [CIDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic                 o_is_hit,
    output logic [ADDR_BITS-1:0] o_block_number,
    output logic [ROW_W-1:0]     o_row_index,
    output logic [LINE_W-1:0]    o_entry_index,
    output logic [TOTAL_W-1:0]   o_hit_total,
    output logic [TOTAL_W-1:0]   o_miss_total
);

    localparam int unsigned STORE = MAX_LINES * MAX_ROWS;
    localparam int unsigned SAW   = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_LINES + 1);
    localparam int unsigned SET_W = $clog2(MAX_ROWS + 1);
    localparam int unsigned LC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int unsigned SC_W  = (SET_W > 3) ? SET_W : 3;
    localparam int unsigned DVD_W = (ADDR_BITS > LFSR_W) ? ADDR_BITS : LFSR_W;
    localparam int unsigned DV0_W = (CNT_W > SET_W) ? CNT_W : SET_W;
    localparam int unsigned DVS_W = (DV0_W > CFG_W) ? DV0_W : CFG_W;

    logic [1:0]       r_mode;
    logic [2:0]       r_pol;
    logic [4:0]       r_lines_cfg;
    logic [2:0]       r_sets_cfg;
    logic [4:0]       r_wpb;

    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_block;
    logic [ROW_W-1:0]     r_row;
    logic [LINE_W-1:0]    r_idx;
    logic [LINE_W-1:0]    r_entry;
    logic                 r_hit;
    logic                 r_free_ok;
    logic [LINE_W-1:0]    r_free_i;
    logic [LINE_W-1:0]    r_min_i;
    logic [USE_W-1:0]     r_min_v;
    logic [USE_W-1:0]     r_hit_use;
    logic [LFSR_W-1:0]    r_lfsr;
    logic [TOTAL_W-1:0]   r_hits;
    logic [TOTAL_W-1:0]   r_misses;
    logic [STORE-1:0]     r_valid;
    logic [STORE-1:0]     r_uv;
    logic                 r_v_rd;
    logic                 r_uv_rd;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [ADDR_BITS-1:0] r_out_block;
    logic [ROW_W-1:0]     r_out_row;
    logic [LINE_W-1:0]    r_out_entry;
    logic [TOTAL_W-1:0]   r_out_hits;
    logic [TOTAL_W-1:0]   r_out_misses;

    logic [CNT_W-1:0]  lines;
    logic [SET_W-1:0]  sets;
    logic [2:0]        pol;
    logic              assoc;
    logic              accept;
    logic [LFSR_W-1:0] lfsr_nxt;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  div_quot;
    logic [DVS_W-1:0]  div_rem;
    logic [SAW-1:0]    rd_addr;
    logic [SAW-1:0]    ent_addr;
    logic [LINE_W-1:0] ent_sel;
    logic [LINE_W-1:0] ent_miss;
    logic [ADDR_BITS-1:0] tag_rd;
    logic [USE_W-1:0]  use_rd;
    logic [USE_W-1:0]  use_now;
    logic [USE_W-1:0]  use_dec;
    logic [USE_W-1:0]  use_eff;
    logic [USE_W-1:0]  use_lines;
    logic              match;
    logic              tag_we;
    logic [SAW-1:0]    tag_waddr;
    logic              use_we;
    logic [SAW-1:0]    use_waddr;
    logic [USE_W-1:0]  use_wdata;
    logic              out_free;
    logic [TOTAL_W-1:0] n_hits;
    logic [TOTAL_W-1:0] n_misses;

    always_comb begin
        if (r_lines_cfg == '0) begin
            lines = CNT_W'(1);
        end else if (LC_W'(r_lines_cfg) > LC_W'(MAX_LINES)) begin
            lines = CNT_W'(MAX_LINES);
        end else begin
            lines = CNT_W'(r_lines_cfg);
        end
        if (r_sets_cfg == '0) begin
            sets = SET_W'(1);
        end else if (SC_W'(r_sets_cfg) > SC_W'(MAX_ROWS)) begin
            sets = SET_W'(MAX_ROWS);
        end else begin
            sets = SET_W'(r_sets_cfg);
        end
        if (r_pol == POL_RANDOM || r_pol == POL_LFU || r_pol == POL_LRU) begin
            pol = r_pol;
        end else begin
            pol = POL_FIFO;
        end
    end

    assign assoc     = (r_mode == MODE_FULL) || (r_mode == MODE_SET);
    assign accept    = i_valid && i_cmd.idle;
    assign use_lines = USE_W'(lines);
    assign lfsr_nxt  = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[LFSR_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= CFG_MODE_RST[1:0];
            r_pol       <= CFG_POLICY_RST;
            r_lines_cfg <= CFG_LINES_RST;
            r_sets_cfg  <= CFG_SETS_RST;
            r_wpb       <= CFG_WPB_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode      <= i_cfg_data[1:0];
                CFG_POLICY: r_pol       <= i_cfg_data[2:0];
                CFG_LINES:  r_lines_cfg <= i_cfg_data;
                CFG_SETS:   r_sets_cfg  <= i_cfg_data[2:0];
                CFG_WPB:    r_wpb       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        unique case (i_cmd.div_sel)
            DV_BLK: begin
                div_dvd = DVD_W'(r_addr);
                div_dvs = (r_wpb == '0) ? DVS_W'(1) : DVS_W'(r_wpb);
            end
            DV_MOD: begin
                div_dvd = DVD_W'(r_block);
                div_dvs = (r_mode == MODE_SET) ? DVS_W'(sets) : DVS_W'(lines);
            end
            DV_RAND: begin
                div_dvd = DVD_W'(lfsr_nxt);
                div_dvs = DVS_W'(lines);
            end
            default: begin
                div_dvd = DVD_W'(r_addr);
                div_dvs = DVS_W'(1);
            end
        endcase
    end

    clu_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign rd_addr  = SAW'(SAW'(r_row) * SAW'(MAX_LINES)) + SAW'(r_idx);
    assign ent_miss = r_free_ok ? r_free_i : ((pol == POL_RANDOM) ? r_entry : r_min_i);
    assign ent_sel  = r_hit ? r_entry : ent_miss;
    assign ent_addr = SAW'(SAW'(r_row) * SAW'(MAX_LINES)) + SAW'(ent_sel);

    clu_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (STORE)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_block),
        .i_raddr (rd_addr),
        .o_rdata (tag_rd)
    );

    clu_ram #(
        .WIDTH (USE_W),
        .DEPTH (STORE)
    ) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (use_we),
        .i_waddr (use_waddr),
        .i_wdata (use_wdata),
        .i_raddr (rd_addr),
        .o_rdata (use_rd)
    );

    always_comb begin
        use_now = r_uv_rd ? use_rd : '0;
        use_dec = (use_now == '0) ? '0 : use_now - 1'b1;
        use_eff = (pol == POL_LRU) ? use_dec : use_now;
        match   = r_v_rd && (tag_rd == r_block);
    end

    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = rd_addr;
        if (i_cmd.dir_ck && !match) begin
            tag_we = 1'b1;
        end else if (i_cmd.update && !r_hit) begin
            tag_we    = 1'b1;
            tag_waddr = ent_addr;
        end
    end

    always_comb begin
        use_we    = 1'b0;
        use_waddr = rd_addr;
        use_wdata = use_dec;
        if (i_cmd.scan_ck && pol == POL_LRU) begin
            use_we = 1'b1;
        end else if (i_cmd.dec_wr) begin
            use_we = 1'b1;
            if (r_idx == r_entry) begin
                use_wdata = use_lines - 1'b1;
            end
        end else if (i_cmd.update) begin
            use_waddr = ent_addr;
            if (pol == POL_LRU) begin
                use_we    = 1'b1;
                use_wdata = use_lines;
            end else if (pol == POL_LFU) begin
                use_we = 1'b1;
                if (!r_hit) begin
                    use_wdata = USE_W'(1);
                end else if (r_hit_use == '1) begin
                    use_wdata = r_hit_use;
                end else begin
                    use_wdata = r_hit_use + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_uv    <= '0;
            r_lfsr  <= LFSR_SEED;
        end else begin
            if (tag_we) begin
                r_valid[tag_waddr] <= 1'b1;
            end
            if (use_we) begin
                r_uv[use_waddr] <= 1'b1;
            end
            if (i_cmd.div_start && i_cmd.div_sel == DV_RAND) begin
                r_lfsr <= lfsr_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v_rd  <= r_valid[rd_addr];
        r_uv_rd <= r_uv[rd_addr];
        if (accept) begin
            r_addr    <= i_word_address;
            r_row     <= '0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end
        if (i_cmd.div_wait && div_done) begin
            unique case (i_cmd.div_sel)
                DV_BLK: r_block <= ADDR_BITS'(div_quot);
                DV_MOD: begin
                    if (assoc) begin
                        r_row <= (r_mode == MODE_SET) ? ROW_W'(div_rem) : '0;
                    end else begin
                        r_entry <= LINE_W'(div_rem);
                        r_idx   <= LINE_W'(div_rem);
                    end
                end
                DV_RAND: r_entry <= LINE_W'(div_rem);
                default: begin
                end
            endcase
        end
        if (i_cmd.dir_ck) begin
            r_hit <= match;
        end
        if (i_cmd.scan_ck) begin
            r_idx <= r_idx + 1'b1;
            if (!r_hit && match) begin
                r_hit     <= 1'b1;
                r_entry   <= r_idx;
                r_hit_use <= use_now;
            end else if (!r_hit && !r_free_ok && !r_v_rd) begin
                r_free_ok <= 1'b1;
                r_free_i  <= r_idx;
            end
            if (r_idx == '0 || use_eff < r_min_v) begin
                r_min_v <= use_eff;
                r_min_i <= r_idx;
            end
        end
        if (i_cmd.update) begin
            r_entry <= ent_sel;
            r_idx   <= '0;
        end
        if (i_cmd.dec_wr) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (r_hit) begin
            if (r_hits != '1) begin
                n_hits = r_hits + 1'b1;
            end
        end else if (r_misses != '1) begin
            n_misses = r_misses + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_hits      <= n_hits;
                r_misses    <= n_misses;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_hit    <= r_hit;
            r_out_block  <= r_block;
            r_out_row    <= r_row;
            r_out_entry  <= r_entry;
            r_out_hits   <= n_hits;
            r_out_misses <= n_misses;
        end
    end

    always_comb begin
        o_sts.div_done  = div_done;
        o_sts.assoc     = assoc;
        o_sts.need_rand = !r_hit && !r_free_ok && (pol == POL_RANDOM);
        o_sts.fifo_miss = !r_hit && (pol == POL_FIFO);
        o_sts.last      = (CNT_W'(r_idx) == lines - 1'b1);
        o_sts.out_free  = out_free;
    end

    assign o_valid        = r_out_valid;
    assign o_is_hit       = r_out_hit;
    assign o_block_number = r_out_block;
    assign o_row_index    = r_out_row;
    assign o_entry_index  = r_out_entry;
    assign o_hit_total    = r_out_hits;
    assign o_miss_total   = r_out_misses;

endmodule

FILE: sv/cache_lookup_replacement_unit.sv
`timescale 1ns / 1ps
// Divisions use a dividend DVD_W bits wide, the wider of ADDR_BITS and 16.
// Direct mapped: two divisions, then a tag read, a tag check and the result hand-off.
// Associative: two divisions, a tag scan over every configured line, a victim pick and an update,
// plus one division for a random victim and a stamp pass over every line for a FIFO miss.
// One transaction in flight; the next is accepted only once the controller is back in idle after the result is loaded.
// Synchronous active-low reset clears valid bits and counters, reseeds the LFSR and restores configuration defaults.
// ----------------------------------------------------------------------------
// Cache lookup and replacement unit
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module cache_lookup_replacement_unit import clu_pkg::*; #(
    parameter int unsigned MAX_LINES = MAX_LINES_DEF,
    parameter int unsigned MAX_ROWS  = MAX_ROWS_DEF,
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEF,
    localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int unsigned LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [ADDR_BITS-1:0] i_word_address,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CIDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_is_hit,
    output logic [ADDR_BITS-1:0] o_block_number,
    output logic [ROW_W-1:0]     o_row_index,
    output logic [LINE_W-1:0]    o_entry_index,
    output logic [TOTAL_W-1:0]   o_hit_total,
    output logic [TOTAL_W-1:0]   o_miss_total
);

    t_cmd    cmd;
    t_status sts;

    clu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    clu_dp #(
        .MAX_LINES (MAX_LINES),
        .MAX_ROWS  (MAX_ROWS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_valid        (i_valid),
        .i_word_address (i_word_address),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_is_hit       (o_is_hit),
        .o_block_number (o_block_number),
        .o_row_index    (o_row_index),
        .o_entry_index  (o_entry_index),
        .o_hit_total    (o_hit_total),
        .o_miss_total   (o_miss_total)
    );

    assign o_ready = cmd.idle;

endmodule

FILE: sv/clu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache lookup checker
// Port-level assertions bound to the top level.
// ----------------------------------------------------------------------------
module clu_checker import clu_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_is_hit,
    input logic [TOTAL_W-1:0] o_hit_total,
    input logic [TOTAL_W-1:0] o_miss_total
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Input accepted while a transaction was in flight.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit_total)))
        else $error("Stalled result changed.");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_hit) |-> (o_hit_total != '0))
        else $error("Hit reported with zero hit total.");

    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_hit) |-> (o_miss_total != '0))
        else $error("Miss reported with zero miss total.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

endmodule

bind cache_lookup_replacement_unit clu_checker u_clu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_is_hit     (o_is_hit),
    .o_hit_total  (o_hit_total),
    .o_miss_total (o_miss_total)
);
